// ===== hw/rtl/plb_pkg.sv =====
package plb_pkg;

	localparam int ENTRY_W = 5;
	localparam int DATA_W  = 32;
	// wide enough for an index into the largest supported list
	localparam int CIDX_W  = 6;

	typedef enum logic [2:0] {
		ACT_INS_HEAD = 3'd0,
		ACT_INS_TAIL = 3'd1,
		ACT_INS_AT   = 3'd2,
		ACT_DEL_HEAD = 3'd3,
		ACT_DEL_TAIL = 3'd4,
		ACT_DEL_AT   = 3'd5,
		ACT_DUMP     = 3'd6
	} action_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_FULL   = 2'd1,
		ST_EMPTY  = 2'd2,
		ST_BADPOS = 2'd3
	} status_t;

	typedef struct packed {
		logic [2:0]               action;
		logic signed [DATA_W-1:0] value;
		logic [4:0]               position;
	} request_t;

	typedef struct packed {
		logic [1:0]               status;
		logic [ENTRY_W-1:0]       entry_count;
		logic signed [DATA_W-1:0] data_out;
		logic                     last;
	} result_t;

	typedef enum logic [1:0] {
		CELL_HOLD = 2'd0,
		CELL_INS  = 2'd1,
		CELL_DEL  = 2'd2,
		CELL_ROT  = 2'd3
	} cell_mode_t;

	typedef struct packed {
		cell_mode_t         mode;
		logic [CIDX_W-1:0]  idx;
		logic [CIDX_W-1:0]  wrap;
	} cell_ctrl_t;

endpackage

// ===== hw/rtl/plb_cell.sv =====
module plb_cell #(
	parameter int IDX = 0
) (
	input  logic                               clk,
	input  plb_pkg::cell_ctrl_t                ctrl,
	input  logic signed [plb_pkg::DATA_W-1:0]  ins_value,
	input  logic signed [plb_pkg::DATA_W-1:0]  left,
	input  logic signed [plb_pkg::DATA_W-1:0]  right,
	input  logic signed [plb_pkg::DATA_W-1:0]  head,
	output logic signed [plb_pkg::DATA_W-1:0]  data,
	output logic signed [plb_pkg::DATA_W-1:0]  tap
);

	localparam logic [plb_pkg::CIDX_W-1:0] MY_IDX = plb_pkg::CIDX_W'(IDX);

	logic signed [plb_pkg::DATA_W-1:0] data_q;
	logic signed [plb_pkg::DATA_W-1:0] data_d;

	always_comb begin
		data_d = data_q;
		case (ctrl.mode)
			plb_pkg::CELL_INS: begin
				if (MY_IDX > ctrl.idx) begin
					data_d = left;
				end else if (MY_IDX == ctrl.idx) begin
					data_d = ins_value;
				end
			end
			plb_pkg::CELL_DEL: begin
				if (MY_IDX >= ctrl.idx) begin
					data_d = right;
				end
			end
			plb_pkg::CELL_ROT: begin
				// the cell at the tail takes the old head, the rest move up one place
				if (MY_IDX == ctrl.wrap) begin
					data_d = head;
				end else begin
					data_d = right;
				end
			end
			default: begin
				data_d = data_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	assign data = data_q;
	assign tap  = (MY_IDX == ctrl.idx) ? data_q : '0;

endmodule

// ===== hw/rtl/positional_list_buffer.sv =====
// channel   direction  handshake                       word
// request   in         start high while busy low       action, value, position
// result    out        strobe high for one cycle       status, entry_count, data_out, last
//
// insert, delete and unused actions: the result word comes out in the cycle after the request is taken
// dump of n entries: n result words back to back, busy high until the last
// dump of an empty list gives a single empty status word
// reset clears the count and the dump state; entry storage is left unset
// results cannot be held off, so nothing inside ever waits on the receiver
module positional_list_buffer #(
	parameter int CAPACITY = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  plb_pkg::request_t request,
	output logic              busy,
	output plb_pkg::result_t  result,
	output logic              strobe
);

	// count width holds CAPACITY itself; compare width also covers the 5-bit position
	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int CMPW = (CW > 5) ? CW : 5;

	// the row of cells, head at index 0
	logic signed [plb_pkg::DATA_W-1:0] cell_q   [CAPACITY];
	logic signed [plb_pkg::DATA_W-1:0] cell_tap [CAPACITY];
	plb_pkg::cell_ctrl_t               ctrl;

	// control state
	logic [CW-1:0]    occ_q, occ_d;
	logic             dump_q, dump_d;
	logic [CW-1:0]    rem_q, rem_d;
	plb_pkg::result_t res_q, res_d;
	logic             strobe_q, strobe_d;

	logic                              accept;
	logic                              full, empty;
	logic [CMPW-1:0]                   pos_ext, occ_ext, cnt_ext;
	logic [plb_pkg::CIDX_W-1:0]        occ_m1, pos_m1;
	logic signed [plb_pkg::DATA_W-1:0] removed;

	genvar gi;
	generate
		for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
			plb_cell #(
				.IDX(gi)
			) u_cell (
				.clk      (clk),
				.ctrl     (ctrl),
				.ins_value(request.value),
				.left     (cell_q[(gi == 0) ? 0 : gi - 1]),
				.right    (cell_q[(gi == CAPACITY - 1) ? gi : gi + 1]),
				.head     (cell_q[0]),
				.data     (cell_q[gi]),
				.tap      (cell_tap[gi])
			);
		end
	endgenerate

	// only the addressed cell drives its tap, so an or collects the removed value
	always_comb begin
		removed = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			removed = removed | cell_tap[i];
		end
	end

	assign accept  = start && !busy;
	assign full    = (occ_q == CW'(CAPACITY));
	assign empty   = (occ_q == '0);
	assign pos_ext = CMPW'(request.position);
	assign occ_ext = CMPW'(occ_q);
	assign occ_m1  = plb_pkg::CIDX_W'(occ_ext - CMPW'(1));
	assign pos_m1  = plb_pkg::CIDX_W'(pos_ext - CMPW'(1));

	always_comb begin
		ctrl     = '{mode: plb_pkg::CELL_HOLD, idx: '0, wrap: '0};
		res_d    = '0;
		strobe_d = 1'b0;
		occ_d    = occ_q;
		dump_d   = dump_q;
		rem_d    = rem_q;
		if (dump_q) begin
			// rotate the row one place and stream out the head
			ctrl.mode      = plb_pkg::CELL_ROT;
			ctrl.wrap      = occ_m1;
			res_d.status   = plb_pkg::ST_OK;
			res_d.data_out = cell_q[0];
			res_d.last     = (rem_q == CW'(1));
			strobe_d       = 1'b1;
			rem_d          = rem_q - CW'(1);
			dump_d         = (rem_q != CW'(1));
		end else if (accept) begin
			strobe_d   = 1'b1;
			res_d.last = 1'b1;
			case (request.action)
				plb_pkg::ACT_INS_HEAD, plb_pkg::ACT_INS_TAIL, plb_pkg::ACT_INS_AT: begin
					if (full) begin
						res_d.status = plb_pkg::ST_FULL;
					end else if (request.action == plb_pkg::ACT_INS_AT &&
							(pos_ext == '0 || pos_ext > occ_ext + CMPW'(1))) begin
						res_d.status = plb_pkg::ST_BADPOS;
					end else begin
						ctrl.mode = plb_pkg::CELL_INS;
						if (request.action == plb_pkg::ACT_INS_HEAD) begin
							ctrl.idx = '0;
						end else if (request.action == plb_pkg::ACT_INS_TAIL) begin
							ctrl.idx = plb_pkg::CIDX_W'(occ_ext);
						end else begin
							ctrl.idx = pos_m1;
						end
						res_d.status = plb_pkg::ST_OK;
						occ_d        = occ_q + CW'(1);
					end
				end
				plb_pkg::ACT_DEL_HEAD, plb_pkg::ACT_DEL_TAIL, plb_pkg::ACT_DEL_AT: begin
					if (empty) begin
						res_d.status = plb_pkg::ST_EMPTY;
					end else if (request.action == plb_pkg::ACT_DEL_AT &&
							(pos_ext == '0 || pos_ext > occ_ext)) begin
						res_d.status = plb_pkg::ST_BADPOS;
					end else begin
						ctrl.mode = plb_pkg::CELL_DEL;
						if (request.action == plb_pkg::ACT_DEL_HEAD) begin
							ctrl.idx = '0;
						end else if (request.action == plb_pkg::ACT_DEL_TAIL) begin
							ctrl.idx = occ_m1;
						end else begin
							ctrl.idx = pos_m1;
						end
						res_d.status   = plb_pkg::ST_OK;
						res_d.data_out = removed;
						occ_d          = occ_q - CW'(1);
					end
				end
				plb_pkg::ACT_DUMP: begin
					if (empty) begin
						res_d.status = plb_pkg::ST_EMPTY;
					end else begin
						// first word goes out now, the rest while busy
						ctrl.mode      = plb_pkg::CELL_ROT;
						ctrl.wrap      = occ_m1;
						res_d.status   = plb_pkg::ST_OK;
						res_d.data_out = cell_q[0];
						res_d.last     = (occ_q == CW'(1));
						dump_d         = (occ_q != CW'(1));
						rem_d          = occ_q - CW'(1);
					end
				end
				default: begin
					res_d.status = plb_pkg::ST_OK;
				end
			endcase
		end
		cnt_ext           = CMPW'(occ_d);
		res_d.entry_count = cnt_ext[plb_pkg::ENTRY_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q    <= '0;
			dump_q   <= 1'b0;
			rem_q    <= '0;
			strobe_q <= 1'b0;
		end else begin
			occ_q    <= occ_d;
			dump_q   <= dump_d;
			rem_q    <= rem_d;
			strobe_q <= strobe_d;
		end
	end

	// result word needs no reset, strobe qualifies it
	always_ff @(posedge clk) begin
		res_q <= res_d;
	end

	assign busy   = dump_q;
	assign result = res_q;
	assign strobe = strobe_q;

	// count never passes the capacity
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= CW'(CAPACITY))
		else $error("occupancy above capacity");

	// every accepted request gives a word on the next cycle
	a_accept_word: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> strobe)
		else $error("accepted request gave no word");

	// each dump cycle gives a word on the next cycle
	a_dump_word: assert property (@(posedge clk) disable iff (!arst_n)
		dump_q |=> strobe)
		else $error("dump cycle gave no word");

	// a word not marked last is always followed by more dump work
	a_more_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !result.last) |-> busy)
		else $error("non-final word with no dump in progress");

	// the count does not move while a dump streams out
	a_dump_count: assert property (@(posedge clk) disable iff (!arst_n)
		dump_q |=> $stable(occ_q))
		else $error("count changed during dump");

endmodule
